// ===== rtl/dcsmf_pkg.sv =====
// package for the dhcp client mac filter: item types, register indexes,
// frame offsets and reset values of the configuration registers
// no dependencies
`timescale 1ns / 1ps

package dcsmf_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SERVER_PORT = 1'b0,
        CFG_CLIENT_PORT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic                  en;
        cfg_index_t            index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_write_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       end_of_frame;
    } item_t;

    // handshake state of the input register toward the check stage
    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctl_t;

    localparam logic [15:0] SERVER_PORT_RST = 16'd67;
    localparam logic [15:0] CLIENT_PORT_RST = 16'd68;

    // byte offsets in the frame
    localparam logic [7:0] MAC_FIRST   = 8'd6;
    localparam logic [7:0] MAC_END     = 8'd12;
    localparam logic [7:0] IHL_POS     = 8'd14;
    localparam logic [7:0] FRAG_HI_POS = 8'd20;
    localparam logic [7:0] FRAG_LO_POS = 8'd21;
    localparam logic [7:0] PROTO_POS   = 8'd23;
    localparam logic [7:0] L4_MIN_POS  = 8'd34;

    // offsets from the start of the udp header
    localparam logic [7:0] UDP_HDR_LEN  = 8'd8;
    localparam logic [7:0] HTYPE_OFS    = 8'd9;
    localparam logic [7:0] HLEN_OFS     = 8'd10;
    localparam logic [7:0] CHADDR_OFS   = 8'd36;
    localparam logic [7:0] CHADDR_END   = 8'd42;
    localparam logic [7:0] DHCP_MIN_END = 8'd52;

    localparam logic [7:0] UDP_PROTO   = 8'd17;
    localparam logic [7:0] HTYPE_ETH   = 8'd1;
    localparam logic [7:0] HLEN_ETH    = 8'd6;
    localparam logic [3:0] IHL_PLAIN   = 4'd5;
    localparam logic [6:0] POS_MAX     = 7'd127;

endpackage

// ===== rtl/dcsmf_in_stage.sv =====
// input register of the dhcp client mac filter
// depends on dcsmf_pkg
`timescale 1ns / 1ps

module dcsmf_in_stage import dcsmf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  item_t      s_item,
    input  logic       advance,
    output stage_ctl_t ctl,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // a slot frees up whenever the held item moves on in the same cycle
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign ctl.valid   = valid_reg;
    assign ctl.advance = advance;
    assign item        = item_reg;

endmodule

// ===== rtl/dcsmf_frame_check.sv =====
// per-frame field capture and verdict of the dhcp client mac filter,
// plus the two port registers; depends on dcsmf_pkg
`timescale 1ns / 1ps

module dcsmf_frame_check import dcsmf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_write_t cfg,
    input  stage_ctl_t ctl,
    input  item_t      item,
    output logic       drop
);

    logic [15:0] server_port_reg;
    logic [15:0] client_port_reg;

    logic [6:0]  pos_reg;
    logic [47:0] mac_reg;
    logic [3:0]  hdr_words_reg;
    logic        udp_reg;
    logic [13:0] frag_reg;
    logic [15:0] sport_reg;
    logic [15:0] dport_reg;
    logic        hw_bad_reg;
    logic        mismatch_reg;

    logic [6:0]  pos_next;
    logic [47:0] mac_next;
    logic [3:0]  hdr_words_next;
    logic        udp_next;
    logic [13:0] frag_next;
    logic [15:0] sport_next;
    logic [15:0] dport_next;
    logic        hw_bad_next;
    logic        mismatch_next;

    logic [7:0]  pos8;
    logic [7:0]  len;
    logic [7:0]  udp_start;
    logic [7:0]  chaddr_idx;
    logic [7:0]  b;
    logic [7:0]  mac_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            server_port_reg <= SERVER_PORT_RST;
            client_port_reg <= CLIENT_PORT_RST;
        end else if (cfg.en) begin
            case (cfg.index)
                CFG_SERVER_PORT: server_port_reg <= cfg.data;
                CFG_CLIENT_PORT: client_port_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        b              = item.frame_byte;
        pos8           = {1'b0, pos_reg};
        len            = pos8 + 8'd1;
        hdr_words_next = (pos8 == IHL_POS) ? b[3:0] : hdr_words_reg;
        udp_start      = 8'd14 + {2'b00, hdr_words_next, 2'b00};
        chaddr_idx     = pos8 - (udp_start + CHADDR_OFS);

        mac_next      = mac_reg;
        frag_next     = frag_reg;
        udp_next      = udp_reg;
        sport_next    = sport_reg;
        dport_next    = dport_reg;
        hw_bad_next   = hw_bad_reg;
        mismatch_next = mismatch_reg;
        pos_next      = (pos_reg < POS_MAX) ? pos_reg + 7'd1 : pos_reg;

        if (pos8 >= MAC_FIRST && pos8 < MAC_END) begin
            mac_next = {mac_reg[39:0], b};
        end
        if (pos8 == FRAG_HI_POS) begin
            frag_next = {b[5:0], frag_reg[7:0]};
        end
        if (pos8 == FRAG_LO_POS) begin
            frag_next = {frag_reg[13:8], b};
        end
        if (pos8 == PROTO_POS) begin
            udp_next = (b == UDP_PROTO);
        end

        // chaddr byte k lines up with source mac byte k, msb first
        case (chaddr_idx[2:0])
            3'd0:    mac_byte = mac_reg[47:40];
            3'd1:    mac_byte = mac_reg[39:32];
            3'd2:    mac_byte = mac_reg[31:24];
            3'd3:    mac_byte = mac_reg[23:16];
            3'd4:    mac_byte = mac_reg[15:8];
            3'd5:    mac_byte = mac_reg[7:0];
            default: mac_byte = 8'd0;
        endcase

        if (pos8 >= L4_MIN_POS) begin
            if (pos8 == udp_start) begin
                sport_next = {b, sport_reg[7:0]};
            end
            if (pos8 == udp_start + 8'd1) begin
                sport_next = {sport_reg[15:8], b};
            end
            if (pos8 == udp_start + 8'd2) begin
                dport_next = {b, dport_reg[7:0]};
            end
            if (pos8 == udp_start + 8'd3) begin
                dport_next = {dport_reg[15:8], b};
            end
            if (pos8 == udp_start + HTYPE_OFS && b != HTYPE_ETH) begin
                hw_bad_next = 1'b1;
            end
            if (pos8 == udp_start + HLEN_OFS && b != HLEN_ETH) begin
                hw_bad_next = 1'b1;
            end
            if (pos8 >= udp_start + CHADDR_OFS && pos8 < udp_start + CHADDR_END
                    && mac_byte != b) begin
                mismatch_next = 1'b1;
            end
        end

        // verdict as if this byte were the last one
        if (len < L4_MIN_POS) begin
            drop = 1'b0;
        end else if (!udp_next) begin
            drop = 1'b0;
        end else if (hdr_words_next < IHL_PLAIN) begin
            drop = 1'b1;
        end else if (len < udp_start + UDP_HDR_LEN) begin
            drop = 1'b0;
        end else if (dport_next != server_port_reg) begin
            drop = 1'b0;
        end else if (sport_next != client_port_reg) begin
            drop = 1'b1;
        end else if (hdr_words_next != IHL_PLAIN) begin
            drop = 1'b1;
        end else if (frag_next != 14'd0) begin
            drop = 1'b1;
        end else if (len < udp_start + DHCP_MIN_END) begin
            drop = 1'b1;
        end else if (hw_bad_next || mismatch_next) begin
            drop = 1'b1;
        end else begin
            drop = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            mac_reg       <= '0;
            hdr_words_reg <= '0;
            udp_reg       <= 1'b0;
            frag_reg      <= '0;
            sport_reg     <= '0;
            dport_reg     <= '0;
            hw_bad_reg    <= 1'b0;
            mismatch_reg  <= 1'b0;
        end else if (ctl.advance) begin
            if (item.end_of_frame) begin
                pos_reg       <= '0;
                mac_reg       <= '0;
                hdr_words_reg <= '0;
                udp_reg       <= 1'b0;
                frag_reg      <= '0;
                sport_reg     <= '0;
                dport_reg     <= '0;
                hw_bad_reg    <= 1'b0;
                mismatch_reg  <= 1'b0;
            end else begin
                pos_reg       <= pos_next;
                mac_reg       <= mac_next;
                hdr_words_reg <= hdr_words_next;
                udp_reg       <= udp_next;
                frag_reg      <= frag_next;
                sport_reg     <= sport_next;
                dport_reg     <= dport_next;
                hw_bad_reg    <= hw_bad_next;
                mismatch_reg  <= mismatch_next;
            end
        end
    end

endmodule

// ===== rtl/dcsmf_out_stage.sv =====
// result register of the dhcp client mac filter
// depends on dcsmf_pkg
`timescale 1ns / 1ps

module dcsmf_out_stage import dcsmf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  stage_ctl_t ctl,
    input  item_t      item,
    input  logic       drop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_drop
);

    logic valid_reg;
    logic valid_next;
    logic drop_reg;
    logic load;

    assign load = ctl.advance && item.end_of_frame;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            drop_reg <= drop;
        end
    end

    assign m_valid = valid_reg;
    assign m_drop  = drop_reg;

endmodule

// ===== rtl/dhcp_chaddr_source_mac_filter.sv =====
// top level of the dhcp client mac filter: input register, frame check, result register
// depends on dcsmf_pkg, dcsmf_in_stage, dcsmf_frame_check, dcsmf_out_stage
//
//   channel  | ports                                  | moves
//   ---------+----------------------------------------+------------------------------
//   input    | s_valid s_ready s_frame_byte s_end_of_frame | one frame byte per item
//   result   | m_valid m_ready m_drop                 | one verdict per frame
//   config   | cfg_wr_en cfg_index cfg_wdata          | server port, client port
//
// one item per cycle sustained, except while an item ending a frame waits on a stalled verdict;
// a verdict reaches m_valid through the input register, then the result register
// only items that end a frame wait on the result register; other items move on
// even while a verdict is stalled on m_ready
// synchronous active-low reset clears all frame state and loads ports 67 and 68
`timescale 1ns / 1ps

module dhcp_chaddr_source_mac_filter import dcsmf_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // config writes
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    // frame bytes in
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_frame_byte,
    input  logic                   s_end_of_frame,
    // verdicts out
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_drop
);

    cfg_write_t cfg;
    item_t      s_item;
    item_t      item;
    stage_ctl_t ctl;
    logic       advance;
    logic       drop;

    assign cfg.en    = cfg_wr_en;
    assign cfg.index = cfg_index_t'(cfg_index);
    assign cfg.data  = cfg_wdata;

    assign s_item.frame_byte   = s_frame_byte;
    assign s_item.end_of_frame = s_end_of_frame;

    // held byte moves into the frame state unless it ends a frame and the
    // previous verdict is still waiting
    assign advance = ctl.valid && (!item.end_of_frame || !m_valid || m_ready);

    dcsmf_in_stage u_in_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .advance (advance),
        .ctl     (ctl),
        .item    (item)
    );

    // field capture and verdict on the held byte
    dcsmf_frame_check u_frame_check (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .ctl     (ctl),
        .item    (item),
        .drop    (drop)
    );

    // verdict register toward the result channel
    dcsmf_out_stage u_out_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .item    (item),
        .drop    (drop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_drop  (m_drop)
    );

    // a byte only moves on when one is held
    a_advance_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |-> ctl.valid)
        else $error("advance without a held item");

    // the end of a frame always produces a verdict in the next cycle
    a_eof_gives_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && item.end_of_frame) |=> m_valid)
        else $error("frame end did not load a verdict");

    // a held byte that cannot move keeps its value
    a_stall_holds_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.valid && !advance) |=> (ctl.valid && $stable(item)))
        else $error("stalled item lost or changed");

endmodule

// ===== bench/testbench.sv =====
// self-checking bench for dhcp_chaddr_source_mac_filter: frames of random content are
// streamed in byte by byte, and every verdict is checked against a built-in predictor
// depends on dcsmf_pkg and the dhcp_chaddr_source_mac_filter rtl
`timescale 1ns / 1ps

module testbench;
    import dcsmf_pkg::*;

    // how a generated frame departs from a well-formed dhcp request
    typedef enum int {
        F_CLEAN,
        F_SRC_PORT,
        F_IHL_LONG,
        F_IHL_SHORT,
        F_FRAGMENT,
        F_SHORT_BODY,
        F_HTYPE,
        F_HLEN,
        F_CHADDR,
        F_OTHER_DPORT,
        F_NOT_UDP,
        F_SHORT_UDP,
        F_SHORT_IP,
        F_NOISE
    } frame_flaw_t;

    localparam int HOLD_CYCLES = 300;

    // tracks frame fields seen so far and queues the drop verdict each frame must get
    class mac_check_scoreboard;
        bit [15:0] server_port;
        bit [15:0] client_port;
        bit [6:0]  byte_pos;
        bit [47:0] src_mac;
        bit [3:0]  ihl;
        bit        udp;
        bit [13:0] frag;
        bit [15:0] sport;
        bit [15:0] dport;
        bit        hw_bad;
        bit        mac_bad;
        bit        expected_drops[$];
        int        errors;

        function new();
            server_port = SERVER_PORT_RST;
            client_port = CLIENT_PORT_RST;
            errors = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            byte_pos = '0;
            src_mac = '0;
            ihl = '0;
            udp = 1'b0;
            frag = '0;
            sport = '0;
            dport = '0;
            hw_bad = 1'b0;
            mac_bad = 1'b0;
        endfunction

        function void write_reg(cfg_index_t idx, bit [15:0] value);
            case (idx)
                CFG_SERVER_PORT: server_port = value;
                CFG_CLIENT_PORT: client_port = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_drops.size();
        endfunction

        function bit frame_verdict(int unsigned len);
            int unsigned u;
            u = 14 + 4 * ihl;
            if (len < 34) return 1'b0;
            if (!udp) return 1'b0;
            if (ihl < IHL_PLAIN) return 1'b1;
            if (len < u + 8) return 1'b0;
            if (dport != server_port) return 1'b0;
            if (sport != client_port) return 1'b1;
            if (ihl != IHL_PLAIN) return 1'b1;
            if (frag != 0) return 1'b1;
            if (len < u + 52) return 1'b1;
            if (hw_bad) return 1'b1;
            if (mac_bad) return 1'b1;
            return 1'b0;
        endfunction

        function void note_byte(bit [7:0] b, bit last);
            int unsigned p;
            int unsigned u;
            int unsigned k;
            p = byte_pos;
            u = 14 + 4 * ihl;
            if (p >= 6 && p < 12) src_mac = {src_mac[39:0], b};
            if (p == 14) begin
                ihl = b[3:0];
                u = 14 + 4 * ihl;
            end
            if (p == 20) frag[13:8] = b[5:0];
            if (p == 21) frag[7:0] = b;
            if (p == 23) udp = (b == UDP_PROTO);
            if (p >= 34) begin
                if (p == u) sport[15:8] = b;
                if (p == u + 1) sport[7:0] = b;
                if (p == u + 2) dport[15:8] = b;
                if (p == u + 3) dport[7:0] = b;
                if (p == u + 9 && b != HTYPE_ETH) hw_bad = 1'b1;
                if (p == u + 10 && b != HLEN_ETH) hw_bad = 1'b1;
                if (p >= u + 36 && p < u + 42) begin
                    k = p - (u + 36);
                    if (src_mac[(5 - k) * 8 +: 8] != b) mac_bad = 1'b1;
                end
            end
            if (last) begin
                expected_drops.push_back(frame_verdict(p + 1));
                clear_frame();
            end else if (byte_pos != POS_MAX) begin
                byte_pos++;
            end
        endfunction

        function void check_verdict(logic drop);
            bit want;
            if (expected_drops.size() == 0) begin
                $error("drop: unexpected verdict %0b, no frame pending", drop);
                errors++;
                return;
            end
            want = expected_drops.pop_front();
            if (drop !== want) begin
                $error("drop mismatch: expected %0b, actual %0b", want, drop);
                errors++;
            end
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    logic [7:0]             s_frame_byte;
    logic                   s_end_of_frame;
    logic                   m_valid;
    logic                   m_ready;
    logic                   m_drop;

    mac_check_scoreboard sb = new();

    bit [7:0] frame_buf [256];   // frame under construction, sent from index 0
    int       src_idle_pct = 0;  // chance of a sender gap before each byte
    int       snk_idle_pct = 0;  // chance of a receiver stall burst per cycle
    bit       hold_req = 1'b0;   // asks the receiver for one long hold-off
    int       bytes_sent = 0;
    int       frames_sent = 0;

    dhcp_chaddr_source_mac_filter u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_frame_byte   (s_frame_byte),
        .s_end_of_frame (s_end_of_frame),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_drop         (m_drop)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watch both channels at each edge; values read here are the pre-edge ones
    // check before noting, so a result never meets its own frame's expectation
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_verdict(m_drop);
            if (s_valid && s_ready) sb.note_byte(s_frame_byte, s_end_of_frame);
        end
    end

    // fills frame_buf with a frame of the given kind and returns its length
    // ihl_sel and len_sel below zero mean a random pick suited to the kind
    function automatic int make_frame(frame_flaw_t flaw, int ihl_sel, int len_sel);
        bit [3:0]  ihl;
        bit [15:0] port;
        bit [13:0] frag;
        int        u;
        int        k;
        int        len;
        foreach (frame_buf[i]) frame_buf[i] = $urandom_range(0, 255);
        if (flaw == F_NOISE) return (len_sel > 0) ? len_sel : $urandom_range(1, 150);

        if (ihl_sel >= 0) ihl = ihl_sel[3:0];
        else if (flaw == F_IHL_LONG) ihl = $urandom_range(6, 15);
        else if (flaw == F_IHL_SHORT) ihl = $urandom_range(0, 4);
        else ihl = IHL_PLAIN;
        u = 14 + 4 * ihl;

        // ethertype mostly ipv4, though the block ignores it
        if ($urandom_range(0, 3) != 0) begin
            frame_buf[12] = 8'h08;
            frame_buf[13] = 8'h00;
        end
        frame_buf[14] = {($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'h4, ihl};
        // keep the two top flag bits random, clear the checked fragment bits
        frame_buf[20][5:0] = 6'h00;
        frame_buf[21] = 8'h00;
        if (flaw == F_FRAGMENT) begin
            frag = $urandom_range(1, 16383);
            frame_buf[20][5:0] = frag[13:8];
            frame_buf[21] = frag[7:0];
        end
        frame_buf[23] = UDP_PROTO;
        if (flaw == F_NOT_UDP) begin
            frame_buf[23] = $urandom_range(0, 254);
            if (frame_buf[23] >= UDP_PROTO) frame_buf[23]++;
        end

        // udp and dhcp fields only where they cannot overlap the ip header
        if (ihl >= IHL_PLAIN) begin
            port = sb.client_port;
            if (flaw == F_SRC_PORT) port ^= 16'($urandom_range(1, 65535));
            frame_buf[u]     = port[15:8];
            frame_buf[u + 1] = port[7:0];
            port = sb.server_port;
            if (flaw == F_OTHER_DPORT) port ^= 16'($urandom_range(1, 65535));
            frame_buf[u + 2] = port[15:8];
            frame_buf[u + 3] = port[7:0];
            frame_buf[u + 9]  = HTYPE_ETH;
            frame_buf[u + 10] = HLEN_ETH;
            if (flaw == F_HTYPE) frame_buf[u + 9] ^= 8'($urandom_range(1, 255));
            if (flaw == F_HLEN) frame_buf[u + 10] ^= 8'($urandom_range(1, 255));
            for (k = 0; k < 6; k++) frame_buf[u + 36 + k] = frame_buf[6 + k];
            if (flaw == F_CHADDR) begin
                k = $urandom_range(0, 5);
                frame_buf[u + 36 + k] ^= 8'(1 << $urandom_range(0, 7));
            end
        end

        if (len_sel > 0) return len_sel;
        case (flaw)
            F_SHORT_IP:   len = $urandom_range(1, 33);
            F_SHORT_UDP:  len = $urandom_range(34, u + 7);
            F_SHORT_BODY: len = $urandom_range(u + 8, u + 51);
            F_IHL_SHORT:  len = $urandom_range(34, 127);
            default: begin
                // now and then well past the 128-byte saturation point
                if ($urandom_range(0, 7) == 0) len = u + 52 + $urandom_range(0, 120);
                else len = u + 52 + $urandom_range(0, 20);
            end
        endcase
        return len;
    endfunction

    // offers one item and returns right after the edge that accepts it
    task automatic send_byte(bit [7:0] b, bit last);
        int gap;
        if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 17);
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_frame_byte   <= b;
        s_end_of_frame <= last;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    task automatic send_frame(int len);
        for (int i = 0; i < len; i++) send_byte(frame_buf[i], i == len - 1);
        frames_sent++;
    endtask

    // both ports are rewritten only once the block has drained; the extra edge
    // lets the monitor note the last accepted item first
    task automatic write_ports(bit [15:0] srv, bit [15:0] cli);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_SERVER_PORT;
        cfg_wdata <= srv;
        @(posedge aclk);
        sb.write_reg(CFG_SERVER_PORT, srv);
        cfg_index <= CFG_CLIENT_PORT;
        cfg_wdata <= cli;
        @(posedge aclk);
        sb.write_reg(CFG_CLIENT_PORT, cli);
        cfg_wr_en <= 1'b0;
    endtask

    // mostly requests, clean or with one defect, plus some raw noise
    task automatic run_random(int min_bytes, int min_frames);
        int          bytes0;
        int          frames0;
        int          r;
        frame_flaw_t flaw;
        bytes0 = bytes_sent;
        frames0 = frames_sent;
        while (bytes_sent - bytes0 < min_bytes || frames_sent - frames0 < min_frames) begin
            r = $urandom_range(0, 99);
            if (r < 10) flaw = F_NOISE;
            else if (r < 45) flaw = F_CLEAN;
            else flaw = frame_flaw_t'($urandom_range(F_SRC_PORT, F_SHORT_IP));
            send_frame(make_frame(flaw, -1, -1));
        end
    endtask

    // receiver: random stall bursts, plus one long hold-off on request
    initial begin
        int gap;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (snk_idle_pct > 0 && $urandom_range(0, 99) < snk_idle_pct) begin
                m_ready <= 1'b0;
                gap = $urandom_range(1, 17);
                repeat (gap) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        #20_000_000;
        $display("dhcp_chaddr_source_mac_filter regression: fail");
        $finish;
    end

    initial begin
        bit [15:0] port;
        aresetn        <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_index      <= CFG_SERVER_PORT;
        cfg_wdata      <= '0;
        s_valid        <= 1'b0;
        s_frame_byte   <= '0;
        s_end_of_frame <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed frames on the reset ports 67 and 68
        src_idle_pct = 20;
        snk_idle_pct = 20;
        foreach (frame_buf[i]) frame_buf[i] = 8'hFF;
        send_frame(1);                                   // single-byte frame
        foreach (frame_buf[i]) frame_buf[i] = 8'h00;
        send_frame(33);                                  // one byte short of an ip header
        send_frame(make_frame(F_SHORT_IP, -1, 33));      // udp, but still too short
        send_frame(make_frame(F_NOT_UDP, -1, 40));
        send_frame(make_frame(F_IHL_SHORT, 0, 34));      // ihl zero drops
        send_frame(make_frame(F_IHL_SHORT, 4, 40));
        send_frame(make_frame(F_SHORT_UDP, -1, 34));
        send_frame(make_frame(F_SHORT_UDP, -1, 41));     // last length without full udp header
        send_frame(make_frame(F_OTHER_DPORT, -1, 42));
        send_frame(make_frame(F_SRC_PORT, -1, 42));
        send_frame(make_frame(F_IHL_LONG, 15, 126));     // full body behind a long ip header
        send_frame(make_frame(F_FRAGMENT, -1, 42));
        send_frame(make_frame(F_SHORT_BODY, -1, 42));
        send_frame(make_frame(F_SHORT_BODY, -1, 85));    // one byte short of a dhcp body
        send_frame(make_frame(F_HTYPE, -1, 86));
        send_frame(make_frame(F_HLEN, -1, 86));
        send_frame(make_frame(F_CHADDR, -1, 86));
        send_frame(make_frame(F_CLEAN, -1, 86));         // shortest passing request
        send_frame(make_frame(F_CLEAN, -1, 127));
        send_frame(make_frame(F_CLEAN, -1, 128));        // length saturates here
        send_frame(make_frame(F_CLEAN, -1, 140));

        // random ports, balanced idling
        write_ports(16'($urandom), 16'($urandom));
        src_idle_pct = 25;
        snk_idle_pct = 25;
        run_random(40, 1);

        // extreme ports; short frames pile up behind a long receiver hold-off
        write_ports(16'h0000, 16'hFFFF);
        src_idle_pct = 0;
        hold_req = 1'b1;
        repeat (20) send_frame(make_frame(F_NOISE, -1, $urandom_range(1, 3)));
        src_idle_pct = 10;
        snk_idle_pct = 40;
        run_random(40, 1);

        write_ports(16'hFFFF, 16'h0000);
        src_idle_pct = 40;
        snk_idle_pct = 10;
        run_random(40, 1);

        // server and client on the same port
        port = 16'($urandom);
        write_ports(port, port);
        src_idle_pct = 15;
        snk_idle_pct = 15;
        run_random(40, 1);

        // back to the usual dhcp ports, no idling at all
        write_ports(SERVER_PORT_RST, CLIENT_PORT_RST);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_random(40, 1);

        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("dhcp_chaddr_source_mac_filter regression: pass");
        end else begin
            $display("dhcp_chaddr_source_mac_filter regression: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/dcsmf_pkg.sv
rtl/dcsmf_in_stage.sv
rtl/dcsmf_frame_check.sv
rtl/dcsmf_out_stage.sv
rtl/dhcp_chaddr_source_mac_filter.sv
bench/testbench.sv
